@@ hdl/chbd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and byte-class helpers for the chunked body decoder.
// No dependencies; every other file in hdl imports this package.
package chbd_pkg;

  // Byte count limit for consumed_cnt (saturating, never above 32 bits).
  localparam int unsigned COUNT_WIDTH = 32;
  localparam logic [32:0] CNT_LIMIT = (COUNT_WIDTH >= 32) ? 33'h0_FFFF_FFFF :
                                      ((33'd1 << COUNT_WIDTH) - 33'd1);

  localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

  // Result kinds, carried on out_tuser.
  localparam logic [1:0] KIND_BODY  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;
  localparam logic [1:0] KIND_LARGE = 2'd3;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 72;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        message_start;
    logic [31:0] start_offset;
  } in_item_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  body_byte;
    logic [31:0] consumed_cnt;
    logic [31:0] body_length;
  } result_t;

  function automatic logic is_ws(input logic [7:0] b);
    is_ws = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // Bit 4 flags a hex digit, bits 3:0 give its value.
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [7:0] t;
    t = 8'h00;
    hex_val = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      t = b - 8'h30;
      hex_val = {1'b1, t[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      t = b - 8'h57;
      hex_val = {1'b1, t[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      t = b - 8'h37;
      hex_val = {1'b1, t[3:0]};
    end
  endfunction

endpackage

@@ hdl/chbd_in_reg.sv @@
`timescale 1ns / 1ps
// Input register of the chunked body decoder: unpacks and holds one item.
// Depends on chbd_pkg.
module chbd_in_reg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [chbd_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tuser,
  input  logic                               advance,
  output logic                               item_valid,
  output chbd_pkg::in_item_t                 item
);
  import chbd_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  // Take a new item when empty or when the held one moves on this cycle.
  assign in_tready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.data_byte     <= in_tdata[7:0];
      item_r.message_start <= in_tuser;
      item_r.start_offset  <= in_tdata[39:8];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ hdl/chbd_parser.sv @@
`timescale 1ns / 1ps
// Parser state and single-byte step logic of the chunked body decoder.
// Depends on chbd_pkg; state advances on each step strobe.
module chbd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  chbd_pkg::in_item_t item,
  input  logic [31:0]        max_body,
  output chbd_pkg::result_t  res
);
  import chbd_pkg::*;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_LEAD    = 4'd1;
  localparam logic [3:0] PH_DIGITS  = 4'd2;
  localparam logic [3:0] PH_TRAIL   = 4'd3;
  localparam logic [3:0] PH_EXT     = 4'd4;
  localparam logic [3:0] PH_DATA    = 4'd5;
  localparam logic [3:0] PH_DATA_CR = 4'd6;
  localparam logic [3:0] PH_DATA_LF = 4'd7;
  localparam logic [3:0] PH_TAIL    = 4'd8;

  logic [3:0]  phase_r, phase_nxt;
  logic [32:0] acc_r, acc_nxt;
  logic        ovl_r, ovl_nxt;
  logic [4:0]  dig_r, dig_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] tot_r, tot_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] base_r, base_nxt;
  logic [23:0] recent_r, recent_nxt;
  logic [2:0]  tseen_r, tseen_nxt;

  // Values after an optional restart by message_start.
  logic        ms;
  logic [3:0]  phase_e;
  logic [32:0] acc_e;
  logic        ovl_e;
  logic [4:0]  dig_e;
  logic [31:0] rem_e, tot_e, cnt_e, base_e;
  logic [23:0] recent_e;
  logic [2:0]  tseen_e;

  logic [7:0]  b;
  logic [4:0]  hv;
  logic        is_hex, prev_cr, lf_end;
  logic        signif, too_many;
  logic [4:0]  dig_inc;
  logic [36:0] prod;
  logic [33:0] need_tot;
  logic        le_zero, le_large;
  logic [2:0]  tseen_inc;
  logic [32:0] cons_sum;
  logic        has_res;
  logic [1:0]  kind;

  assign b  = item.data_byte;
  assign ms = item.message_start;

  always_comb begin
    phase_e  = ms ? PH_LEAD : phase_r;
    acc_e    = ms ? 33'd0 : acc_r;
    ovl_e    = ms ? 1'b0 : ovl_r;
    dig_e    = ms ? 5'd0 : dig_r;
    rem_e    = ms ? 32'd0 : rem_r;
    tot_e    = ms ? 32'd0 : tot_r;
    cnt_e    = ms ? 32'd0 : cnt_r;
    base_e   = ms ? item.start_offset : base_r;
    recent_e = ms ? 24'd0 : recent_r;
    tseen_e  = ms ? 3'd0 : tseen_r;
  end

  always_comb begin
    hv      = hex_val(b);
    is_hex  = hv[4];
    prev_cr = (recent_e[7:0] == CH_CR);
    lf_end  = (b == CH_LF) && prev_cr;

    // One hex digit into the size; leading zeros do not count as digits.
    signif   = (acc_e != 33'd0) || ovl_e || (hv[3:0] != 4'd0);
    dig_inc  = (signif && dig_e < 5'd17) ? dig_e + 5'd1 : dig_e;
    too_many = signif && (dig_inc > 5'd16);
    prod     = {acc_e, 4'b0000} | {33'd0, hv[3:0]};

    need_tot = {2'b00, tot_e} + {1'b0, acc_e};
    le_zero  = !ovl_e && (acc_e == 33'd0);
    le_large = ovl_e || (need_tot > {2'b00, max_body});

    tseen_inc = (tseen_e < 3'd4) ? tseen_e + 3'd1 : tseen_e;
  end

  always_comb begin
    phase_nxt  = phase_e;
    acc_nxt    = acc_e;
    ovl_nxt    = ovl_e;
    dig_nxt    = dig_e;
    rem_nxt    = rem_e;
    tot_nxt    = tot_e;
    cnt_nxt    = cnt_e;
    base_nxt   = base_e;
    recent_nxt = recent_e;
    tseen_nxt  = tseen_e;
    has_res    = 1'b0;
    kind       = KIND_BODY;

    if (phase_e != PH_IDLE) begin
      cnt_nxt    = (cnt_e == 32'hFFFF_FFFF) ? cnt_e : cnt_e + 32'd1;
      recent_nxt = {recent_e[15:0], b};

      unique case (phase_e) inside
        PH_LEAD, PH_DIGITS: begin
          if (phase_e == PH_LEAD && lf_end) begin
            has_res = 1'b1;
            kind    = KIND_BAD;
          end else if (phase_e == PH_LEAD && is_ws(b)) begin
            // skip leading whitespace
          end else if (is_hex) begin
            dig_nxt = dig_inc;
            if (!ovl_e) begin
              if (prod > 37'h0_FFFF_FFFF) begin
                ovl_nxt = 1'b1;
                acc_nxt = 33'h1_0000_0000;
              end else begin
                acc_nxt = prod[32:0];
              end
            end
            if (too_many) begin
              has_res = 1'b1;
              kind    = KIND_BAD;
            end else begin
              phase_nxt = PH_DIGITS;
            end
          end else if (phase_e == PH_DIGITS && is_ws(b)) begin
            phase_nxt = PH_TRAIL;
          end else if (phase_e == PH_DIGITS && b == CH_SEMI) begin
            phase_nxt = PH_EXT;
          end else begin
            has_res = 1'b1;
            kind    = KIND_BAD;
          end
        end
        PH_TRAIL, PH_EXT: begin
          if (lf_end) begin
            if (le_zero) begin
              phase_nxt = PH_TAIL;
              tseen_nxt = 3'd0;
            end else if (le_large) begin
              has_res = 1'b1;
              kind    = KIND_LARGE;
            end else begin
              rem_nxt   = acc_e[31:0];
              phase_nxt = PH_DATA;
            end
          end else if (phase_e == PH_EXT || is_ws(b)) begin
            // ignore extension bytes and trailing whitespace
          end else if (b == CH_SEMI) begin
            phase_nxt = PH_EXT;
          end else begin
            has_res = 1'b1;
            kind    = KIND_BAD;
          end
        end
        PH_DATA: begin
          has_res = 1'b1;
          kind    = KIND_BODY;
          tot_nxt = tot_e + 32'd1;
          rem_nxt = rem_e - 32'd1;
          if (rem_e == 32'd1) begin
            phase_nxt = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (b == CH_CR) begin
            phase_nxt = PH_DATA_LF;
          end else begin
            has_res = 1'b1;
            kind    = KIND_BAD;
          end
        end
        PH_DATA_LF: begin
          if (b == CH_LF) begin
            acc_nxt   = 33'd0;
            ovl_nxt   = 1'b0;
            dig_nxt   = 5'd0;
            phase_nxt = PH_LEAD;
          end else begin
            has_res = 1'b1;
            kind    = KIND_BAD;
          end
        end
        PH_TAIL: begin
          tseen_nxt = tseen_inc;
          // Either CRLF right after the zero line, or a trailer ending in CRLFCRLF.
          if ((tseen_inc == 3'd2 && lf_end) ||
              (tseen_inc >= 3'd4 && recent_e == 24'h0D0A0D && b == CH_LF)) begin
            has_res = 1'b1;
            kind    = KIND_DONE;
          end
        end
        default: begin
          has_res = 1'b1;
          kind    = KIND_BAD;
        end
      endcase

      if (has_res && kind != KIND_BODY) begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  assign cons_sum = {1'b0, base_e} + {1'b0, cnt_nxt};

  always_comb begin
    res.valid        = has_res;
    res.kind         = kind;
    res.body_byte    = (kind == KIND_BODY) ? b : 8'd0;
    res.consumed_cnt = 32'd0;
    if (kind == KIND_DONE) begin
      res.consumed_cnt = (cons_sum > CNT_LIMIT) ? CNT_LIMIT[31:0] : cons_sum[31:0];
    end
    res.body_length  = tot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      acc_r    <= 33'd0;
      ovl_r    <= 1'b0;
      dig_r    <= 5'd0;
      rem_r    <= 32'd0;
      tot_r    <= 32'd0;
      cnt_r    <= 32'd0;
      base_r   <= 32'd0;
      recent_r <= 24'd0;
      tseen_r  <= 3'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      ovl_r    <= ovl_nxt;
      dig_r    <= dig_nxt;
      rem_r    <= rem_nxt;
      tot_r    <= tot_nxt;
      cnt_r    <= cnt_nxt;
      base_r   <= base_nxt;
      recent_r <= recent_nxt;
      tseen_r  <= tseen_nxt;
    end
  end

endmodule

@@ hdl/chbd_out_reg.sv @@
`timescale 1ns / 1ps
// Result register of the chunked body decoder: holds one result item until taken.
// Depends on chbd_pkg.
module chbd_out_reg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  chbd_pkg::result_t                 res,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [chbd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [1:0]                        out_tuser
);
  import chbd_pkg::*;

  logic                   valid_r;
  logic [OUT_TDATA_W-1:0] data_r;
  logic [1:0]             kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {res.body_length, res.consumed_cnt, res.body_byte};
      kind_r <= res.kind;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;

endmodule

@@ hdl/http_chunked_body_decoder.sv @@
`timescale 1ns / 1ps
// HTTP/1.1 chunked body decoder, one raw body byte per item.
// Throughput: one item per cycle while out_tready stays high; a held result item
//   stalls the input register, which then drops in_tready.
// Datapath: input register, combinational parser, result register.
// Reset (rst_n low, synchronous): parser idle waiting for a message start,
//   both registers empty, body_limit back to 1048576.
module http_chunked_body_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] data_byte, [39:8] start_offset
  input  logic        in_tuser,   // [0] message_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] body_byte, [39:8] consumed_cnt,
                                  // [71:40] body_length
  output logic [1:0]  out_tuser,  // [1:0] result_kind
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data // body_limit
);
  import chbd_pkg::*;

  logic        item_valid;
  in_item_t    item;
  result_t     res;
  logic        advance;
  logic [31:0] max_body_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= MAX_BODY_RESET;
    end else if (cfg_wr_en) begin
      max_body_r <= cfg_wr_data;
    end
  end

  // Step the held item when the result slot is free or drains this cycle.
  assign advance = item_valid && (!out_tvalid || out_tready);

  chbd_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  chbd_parser u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .item     (item),
    .max_body (max_body_r),
    .res      (res)
  );

  chbd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && res.valid),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_cons_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_DONE |-> out_tdata[39:8] == 32'd0)
    else $error("consumed count on a result that is not complete");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while both registers are full and stalled");

  a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(advance))
    else $error("result appeared without a step");

endmodule
